/* hw/rtl/nfci_pkg.sv */
`default_nettype none

package nfci_pkg;

   // command bytes, compared on the low 8 bits of the masked bus data
   localparam logic [7:0] CMD_UNLOCK_A   = 8'hAA;
   localparam logic [7:0] CMD_UNLOCK_B   = 8'h55;
   localparam logic [7:0] CMD_PROGRAM    = 8'hA0;
   localparam logic [7:0] CMD_AUTOSELECT = 8'h90;
   localparam logic [7:0] CMD_ERASE      = 8'h80;
   localparam logic [7:0] CMD_CHIP_ERASE = 8'h10;
   localparam logic [7:0] CMD_BYPASS     = 8'h20;
   localparam logic [7:0] CMD_RESET      = 8'hF0;
   localparam logic [7:0] CMD_EXIT       = 8'h00;
   localparam logic [7:0] NARROW_MASK    = 8'hFF;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNLOCK_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNLOCK_SECOND = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAKER_CODE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PART_CODE     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PART_ADDR     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDE_BUS      = 3'd5;

   localparam logic [15:0] RST_UNLOCK_FIRST  = 16'h0555;
   localparam logic [15:0] RST_UNLOCK_SECOND = 16'h02AA;
   localparam logic [15:0] RST_MAKER_CODE    = 16'h0001;
   localparam logic [15:0] RST_PART_CODE     = 16'h0000;
   localparam logic [15:0] RST_PART_ADDR     = 16'h0001;

   typedef struct packed {
      logic [15:0] unlock_first;
      logic [15:0] unlock_second;
      logic [15:0] maker_code;
      logic [15:0] part_code;
      logic [15:0] part_addr;
      logic        wide_bus;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/nfci_array.sv */
`default_nettype none

// Flash array: one synchronous RAM, one read and one write port. After reset
// and after a chip erase a sweep writes all ones, one word a cycle.
module nfci_array #(
   parameter int unsigned AW = 16,
   parameter int unsigned DW = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          erase_start,
   output logic               busy
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;
   logic          clear_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;

   assign mem_we    = clear_ff | wr_en;
   assign mem_waddr = clear_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clear_ff ? {DW{1'b1}} : wr_data;
   assign rd_data   = rd_data_ff;
   assign busy      = clear_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (erase_start) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == {AW{1'b1}}) begin
            clear_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/nfci_cmd.sv */
`default_nettype none

// Command state machine and read/program data path for one bus word.
module nfci_cmd #(
   parameter int unsigned AW = 16,
   parameter int unsigned DW = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire nfci_pkg::cfg_type cfg,
   input  wire logic             go,
   input  wire logic             kind,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [15:0]      wdata,
   input  wire logic [DW-1:0]    mem_data,
   output logic [15:0]           rd_result,
   output logic [3:0]            state_result,
   output logic                  err_result,
   output logic                  erase_hit,
   output logic                  prog_en,
   output logic [DW-1:0]         prog_data
);

   typedef enum logic [3:0] {
      ST_READ     = 4'd0,
      ST_UNLOCK1  = 4'd1,
      ST_UNLOCK2  = 4'd2,
      ST_PROGRAM  = 4'd3,
      ST_AUTOSEL  = 4'd4,
      ST_ERASE0   = 4'd5,
      ST_ERASE1   = 4'd6,
      ST_ERASE2   = 4'd7,
      ST_BYPASS   = 4'd8,
      ST_BYP_PROG = 4'd9,
      ST_BYP_EXIT = 4'd10
   } cmd_state_type;

   cmd_state_type state_ff;
   cmd_state_type state_in;

   // last word programmed; the read of the next word may have missed it
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic [DW-1:0] fwd_data_ff;

   logic [DW-1:0] mask;
   logic [DW-1:0] data;
   logic [7:0]    cmd;
   logic          at_first;
   logic          at_second;
   logic [DW-1:0] word;
   logic [DW-1:0] rd_raw;
   logic          ok;
   logic          err;
   logic          prog;
   logic          erase;

   assign mask      = cfg.wide_bus ? {DW{1'b1}} : DW'(nfci_pkg::NARROW_MASK);
   assign data      = wdata[DW-1:0] & mask;
   assign cmd       = data[7:0];
   assign at_first  = addr == cfg.unlock_first[AW-1:0];
   assign at_second = addr == cfg.unlock_second[AW-1:0];
   assign word      = (fwd_valid_ff && fwd_addr_ff == addr) ? fwd_data_ff : mem_data;

   always_comb begin
      if (state_ff == ST_AUTOSEL) begin
         if (addr == '0) begin
            rd_raw = cfg.maker_code[DW-1:0];
         end else if (addr == cfg.part_addr[AW-1:0]) begin
            rd_raw = cfg.part_code[DW-1:0];
         end else begin
            rd_raw = '0;
         end
      end else begin
         rd_raw = word;
      end
   end

   always_comb begin
      state_in = state_ff;
      ok       = 1'b0;
      err      = 1'b0;
      prog     = 1'b0;
      erase    = 1'b0;
      if (!kind) begin
         state_in = state_ff;
      end else if (state_ff == ST_PROGRAM || state_ff == ST_BYP_PROG) begin
         prog     = 1'b1;
         state_in = (state_ff == ST_PROGRAM) ? ST_READ : ST_BYPASS;
      end else if (cmd == nfci_pkg::CMD_RESET) begin
         state_in = ST_READ;
      end else begin
         unique case (state_ff)
            ST_READ: begin
               if (cmd == nfci_pkg::CMD_UNLOCK_A && at_first) begin
                  state_in = ST_UNLOCK1;
                  ok       = 1'b1;
               end
            end
            ST_UNLOCK1: begin
               if (cmd == nfci_pkg::CMD_UNLOCK_B && at_second) begin
                  state_in = ST_UNLOCK2;
                  ok       = 1'b1;
               end
            end
            ST_UNLOCK2: begin
               if (at_first) begin
                  ok = 1'b1;
                  unique case (cmd)
                     nfci_pkg::CMD_PROGRAM:    state_in = ST_PROGRAM;
                     nfci_pkg::CMD_AUTOSELECT: state_in = ST_AUTOSEL;
                     nfci_pkg::CMD_ERASE:      state_in = ST_ERASE0;
                     nfci_pkg::CMD_BYPASS:     state_in = ST_BYPASS;
                     default:                  ok = 1'b0;
                  endcase
               end
            end
            ST_ERASE0: begin
               if (cmd == nfci_pkg::CMD_UNLOCK_A && at_first) begin
                  state_in = ST_ERASE1;
                  ok       = 1'b1;
               end
            end
            ST_ERASE1: begin
               if (cmd == nfci_pkg::CMD_UNLOCK_B && at_second) begin
                  state_in = ST_ERASE2;
                  ok       = 1'b1;
               end
            end
            ST_ERASE2: begin
               if (cmd == nfci_pkg::CMD_CHIP_ERASE && at_first) begin
                  state_in = ST_READ;
                  ok       = 1'b1;
                  erase    = 1'b1;
               end
            end
            ST_BYPASS: begin
               if (cmd == nfci_pkg::CMD_PROGRAM) begin
                  state_in = ST_BYP_PROG;
                  ok       = 1'b1;
               end else if (cmd == nfci_pkg::CMD_AUTOSELECT) begin
                  state_in = ST_BYP_EXIT;
                  ok       = 1'b1;
               end
            end
            ST_BYP_EXIT: begin
               if (cmd == nfci_pkg::CMD_EXIT) begin
                  state_in = ST_READ;
                  ok       = 1'b1;
               end
            end
            default: ok = 1'b0;
         endcase
         if (!ok) begin
            state_in = ST_READ;
            err      = 1'b1;
         end
      end
   end

   assign rd_result    = kind ? 16'h0000 : 16'(rd_raw & mask);
   assign state_result = state_in;
   assign err_result   = err;
   assign erase_hit    = erase;
   assign prog_en      = go & prog;
   assign prog_data    = word & data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READ;
         fwd_valid_ff <= 1'b0;
      end else if (go) begin
         state_ff <= state_in;
         if (prog) begin
            fwd_valid_ff <= 1'b1;
         end else if (erase) begin
            fwd_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && prog) begin
         fwd_addr_ff <= addr;
         fwd_data_ff <= prog_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/nor_flash_command_interpreter.sv */
`default_nettype none

// NOR flash chip model with the JEDEC/AMD command set. Each req word is one
// bus access (read or write); each gives one rsp word with read data, the
// command state after the access and a sequence error flag. The array RAM is
// read when a word is accepted; the word completes once the rsp register is
// free. One word is taken per cycle unless rsp stalls or an erase is pending;
// the single array port pair sets throughput. After reset and a chip erase,
// req_ready is low while the array is swept to all ones at one word per cycle
// over 2**min(ADDR_BITS,16) words (csr writes are taken as usual). A program
// is a read-modify-write; a back-to-back access to the same word is forwarded.
module nor_flash_command_interpreter #(
   parameter int unsigned ADDR_BITS  = 16,
   parameter int unsigned DATA_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_address,
   input  wire logic [15:0] req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_read_data,
   output logic [3:0]       rsp_cmd_state,
   output logic             rsp_sequence_error,
   input  wire logic        csr_we,
   input  wire logic [nfci_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [nfci_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int unsigned AW = (ADDR_BITS < 16) ? ADDR_BITS : 16;

   nfci_pkg::cfg_type cfg_ff;

   logic          s1_valid_ff;
   logic          s1_kind_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [15:0]   s1_data_ff;

   logic          rsp_valid_ff;
   logic [15:0]   rsp_read_data_ff;
   logic [3:0]    rsp_cmd_state_ff;
   logic          rsp_err_ff;

   logic                  accept;
   logic                  go;
   logic                  array_busy;
   logic [DATA_WIDTH-1:0] mem_data;
   logic [15:0]           rd_result;
   logic [3:0]            state_result;
   logic                  err_result;
   logic                  erase_hit;
   logic                  prog_en;
   logic [DATA_WIDTH-1:0] prog_data;

   assign go        = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   // hold off new words while an erase is about to start so none reads stale data
   assign req_ready = !array_busy && !(s1_valid_ff && s1_kind_ff && erase_hit)
                      && (!s1_valid_ff || go);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unlock_first  <= nfci_pkg::RST_UNLOCK_FIRST;
         cfg_ff.unlock_second <= nfci_pkg::RST_UNLOCK_SECOND;
         cfg_ff.maker_code    <= nfci_pkg::RST_MAKER_CODE;
         cfg_ff.part_code     <= nfci_pkg::RST_PART_CODE;
         cfg_ff.part_addr     <= nfci_pkg::RST_PART_ADDR;
         cfg_ff.wide_bus      <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            nfci_pkg::CSR_UNLOCK_FIRST:  cfg_ff.unlock_first  <= csr_wdata;
            nfci_pkg::CSR_UNLOCK_SECOND: cfg_ff.unlock_second <= csr_wdata;
            nfci_pkg::CSR_MAKER_CODE:    cfg_ff.maker_code    <= csr_wdata;
            nfci_pkg::CSR_PART_CODE:     cfg_ff.part_code     <= csr_wdata;
            nfci_pkg::CSR_PART_ADDR:     cfg_ff.part_addr     <= csr_wdata;
            nfci_pkg::CSR_WIDE_BUS:      cfg_ff.wide_bus      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (go) begin
            s1_valid_ff <= 1'b0;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= req_kind;
         s1_addr_ff <= req_address[AW-1:0];
         s1_data_ff <= req_write_data;
      end
      if (go) begin
         rsp_read_data_ff <= rd_result;
         rsp_cmd_state_ff <= state_result;
         rsp_err_ff       <= err_result;
      end
   end

   nfci_array #(
      .AW(AW),
      .DW(DATA_WIDTH)
   ) u_array (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (req_address[AW-1:0]),
      .rd_data    (mem_data),
      .wr_en      (prog_en),
      .wr_addr    (s1_addr_ff),
      .wr_data    (prog_data),
      .erase_start(go && s1_kind_ff && erase_hit),
      .busy       (array_busy)
   );

   nfci_cmd #(
      .AW(AW),
      .DW(DATA_WIDTH)
   ) u_cmd (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .go          (go),
      .kind        (s1_kind_ff),
      .addr        (s1_addr_ff),
      .wdata       (s1_data_ff),
      .mem_data    (mem_data),
      .rd_result   (rd_result),
      .state_result(state_result),
      .err_result  (err_result),
      .erase_hit   (erase_hit),
      .prog_en     (prog_en),
      .prog_data   (prog_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_cmd_state      = rsp_cmd_state_ff;
   assign rsp_sequence_error = rsp_err_ff;

endmodule

`default_nettype wire

/* test/tb_nor_flash_command_interpreter.sv */
`default_nettype none

module tb_nor_flash_command_interpreter;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {BUS_READ = 1'b0, BUS_WRITE = 1'b1} bus_kind_type;

   typedef enum logic [3:0] {
      CS_ARRAY_READ = 4'd0,
      CS_GOT_AA     = 4'd1,
      CS_GOT_55     = 4'd2,
      CS_PROG_WAIT  = 4'd3,
      CS_AUTOSELECT = 4'd4,
      CS_ERASE_80   = 4'd5,
      CS_ERASE_AA   = 4'd6,
      CS_ERASE_55   = 4'd7,
      CS_BYPASS     = 4'd8,
      CS_BYP_PROG   = 4'd9,
      CS_BYP_EXIT   = 4'd10
   } flash_state_type;

   typedef struct packed {
      bus_kind_type kind;
      logic [15:0]  address;
      logic [15:0]  write_data;
      logic [7:0]   gap_after;
   } bus_word_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [3:0]  cmd_state;
      logic        seq_error;
   } flash_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [15:0] req_address = '0;
   logic [15:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [15:0] rsp_read_data;
   logic [3:0]  rsp_cmd_state;
   logic        rsp_sequence_error;
   logic        csr_we = 1'b0;
   logic [nfci_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [nfci_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   nor_flash_command_interpreter u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_address        (req_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_data      (rsp_read_data),
      .rsp_cmd_state      (rsp_cmd_state),
      .rsp_sequence_error (rsp_sequence_error),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial forever #4 clock = ~clock;

   // shadow of the chip
   logic [15:0]       flash_mem [0:65535];
   flash_state_type   flash_state;
   nfci_pkg::cfg_type flash_cfg;

   bus_word_type  bus_pending [$];
   flash_rsp_type rsp_expected [$];
   int unsigned words_queued = 0;
   int unsigned words_accepted = 0;
   int unsigned mismatches = 0;
   int unsigned erase_left = 4;
   logic        gen_calm = 1'b0;
   logic        rsp_calm = 1'b0;
   logic        req_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned rsp_hold = 0;

   task automatic flash_erase_all();
      int i;
      for (i = 0; i < 65536; i++) flash_mem[i] = 16'hFFFF;
   endtask

   task automatic flash_access(input bus_kind_type kind, input logic [15:0] addr,
                               input logic [15:0] wdata, output flash_rsp_type res);
      logic [15:0]     mask;
      logic [15:0]     data;
      logic [15:0]     rd;
      logic [7:0]      cmd;
      logic            at_first;
      logic            at_second;
      logic            ok;
      logic            err;
      flash_state_type nxt;
      mask = flash_cfg.wide_bus ? 16'hFFFF : {8'h00, nfci_pkg::NARROW_MASK};
      data = wdata & mask;
      cmd = data[7:0];
      at_first = addr == flash_cfg.unlock_first;
      at_second = addr == flash_cfg.unlock_second;
      rd = '0;
      err = 1'b0;
      ok = 1'b0;
      nxt = flash_state;
      if (kind == BUS_READ) begin
         if (flash_state == CS_AUTOSELECT) begin
            if (addr == 16'h0000) rd = flash_cfg.maker_code;
            else if (addr == flash_cfg.part_addr) rd = flash_cfg.part_code;
            else rd = '0;
         end else begin
            rd = flash_mem[addr];
         end
         rd = rd & mask;
      end else if (flash_state == CS_PROG_WAIT || flash_state == CS_BYP_PROG) begin
         // any write is program data here, reset byte included
         flash_mem[addr] = flash_mem[addr] & data;
         nxt = (flash_state == CS_PROG_WAIT) ? CS_ARRAY_READ : CS_BYPASS;
      end else if (cmd == nfci_pkg::CMD_RESET) begin
         nxt = CS_ARRAY_READ;
      end else begin
         case (flash_state)
            CS_ARRAY_READ: if (cmd == nfci_pkg::CMD_UNLOCK_A && at_first) begin
               nxt = CS_GOT_AA;
               ok = 1'b1;
            end
            CS_GOT_AA: if (cmd == nfci_pkg::CMD_UNLOCK_B && at_second) begin
               nxt = CS_GOT_55;
               ok = 1'b1;
            end
            CS_GOT_55: if (at_first) begin
               ok = 1'b1;
               case (cmd)
                  nfci_pkg::CMD_PROGRAM:    nxt = CS_PROG_WAIT;
                  nfci_pkg::CMD_AUTOSELECT: nxt = CS_AUTOSELECT;
                  nfci_pkg::CMD_ERASE:      nxt = CS_ERASE_80;
                  nfci_pkg::CMD_BYPASS:     nxt = CS_BYPASS;
                  default:                  ok = 1'b0;
               endcase
            end
            CS_ERASE_80: if (cmd == nfci_pkg::CMD_UNLOCK_A && at_first) begin
               nxt = CS_ERASE_AA;
               ok = 1'b1;
            end
            CS_ERASE_AA: if (cmd == nfci_pkg::CMD_UNLOCK_B && at_second) begin
               nxt = CS_ERASE_55;
               ok = 1'b1;
            end
            CS_ERASE_55: if (cmd == nfci_pkg::CMD_CHIP_ERASE && at_first) begin
               flash_erase_all();
               nxt = CS_ARRAY_READ;
               ok = 1'b1;
            end
            CS_BYPASS: begin
               // bypass commands are taken at any address
               if (cmd == nfci_pkg::CMD_PROGRAM) begin
                  nxt = CS_BYP_PROG;
                  ok = 1'b1;
               end else if (cmd == nfci_pkg::CMD_AUTOSELECT) begin
                  nxt = CS_BYP_EXIT;
                  ok = 1'b1;
               end
            end
            CS_BYP_EXIT: if (cmd == nfci_pkg::CMD_EXIT) begin
               nxt = CS_ARRAY_READ;
               ok = 1'b1;
            end
            default: ;
         endcase
         if (!ok) begin
            nxt = CS_ARRAY_READ;
            err = 1'b1;
         end
      end
      flash_state = nxt;
      res.read_data = rd;
      res.cmd_state = nxt;
      res.seq_error = err;
   endtask

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 100)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   function automatic logic [7:0] pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 8'd0;
      if (r < 85) return 8'($urandom_range(1, 3));
      if (r < 97) return 8'($urandom_range(4, 12));
      return 8'($urandom_range(20, 40));
   endfunction

   function automatic logic [15:0] pick_addr();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35) return 16'($urandom_range(0, 15));
      if (r < 50) begin
         case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return flash_cfg.unlock_first;
            3: return flash_cfg.unlock_second;
            default: return flash_cfg.part_addr;
         endcase
      end
      return 16'($urandom());
   endfunction

   function automatic logic [15:0] pick_data();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {8'($urandom()), nfci_pkg::CMD_RESET};
         default: return 16'($urandom());
      endcase
   endfunction

   // command byte, upper byte junk half the time
   function automatic logic [15:0] cmd_word(input logic [7:0] cmd);
      return {($urandom_range(0, 1) != 0) ? 8'($urandom()) : 8'h00, cmd};
   endfunction

   task automatic queue_word(input bus_kind_type kind, input logic [15:0] addr,
                             input logic [15:0] data);
      bus_word_type w;
      if ($urandom_range(0, 29) == 0) gen_calm = !gen_calm;
      w.kind = kind;
      w.address = addr;
      w.write_data = data;
      w.gap_after = gen_calm ? 8'd0 : pick_gap();
      bus_pending.push_back(w);
      words_queued++;
   endtask

   task automatic put_write(input logic [15:0] addr, input logic [15:0] data);
      queue_word(BUS_WRITE, addr, data);
   endtask

   task automatic put_read(input logic [15:0] addr);
      queue_word(BUS_READ, addr, 16'($urandom()));
   endtask

   task automatic put_unlock();
      put_write(flash_cfg.unlock_first, cmd_word(nfci_pkg::CMD_UNLOCK_A));
      put_write(flash_cfg.unlock_second, cmd_word(nfci_pkg::CMD_UNLOCK_B));
   endtask

   task automatic seq_program();
      logic [15:0] a;
      a = pick_addr();
      put_unlock();
      put_write(flash_cfg.unlock_first, cmd_word(nfci_pkg::CMD_PROGRAM));
      put_write(a, pick_data());
      if ($urandom_range(0, 1) != 0) put_read(a);
   endtask

   task automatic seq_autoselect();
      int unsigned n;
      n = $urandom_range(1, 4);
      put_unlock();
      put_write(flash_cfg.unlock_first, cmd_word(nfci_pkg::CMD_AUTOSELECT));
      repeat (n) begin
         case ($urandom_range(0, 2))
            0: put_read(16'h0000);
            1: put_read(flash_cfg.part_addr);
            default: put_read(pick_addr());
         endcase
      end
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
            put_write(pick_addr(), cmd_word(nfci_pkg::CMD_RESET));
         12, 13, 14, 15, 16: put_write(pick_addr(), 16'($urandom()));
         default: ;
      endcase
   endtask

   task automatic seq_bypass();
      int unsigned n;
      logic [15:0] a;
      n = $urandom_range(1, 4);
      put_unlock();
      put_write(flash_cfg.unlock_first, cmd_word(nfci_pkg::CMD_BYPASS));
      repeat (n) begin
         if ($urandom_range(0, 2) != 0) begin
            a = pick_addr();
            put_write(pick_addr(), cmd_word(nfci_pkg::CMD_PROGRAM));
            put_write(a, pick_data());
            if ($urandom_range(0, 1) != 0) put_read(a);
         end else begin
            put_read(pick_addr());
         end
      end
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
            put_write(pick_addr(), cmd_word(nfci_pkg::CMD_AUTOSELECT));
            put_write(pick_addr(), cmd_word(nfci_pkg::CMD_EXIT));
         end
         10, 11, 12, 13: begin
            put_write(pick_addr(), cmd_word(nfci_pkg::CMD_AUTOSELECT));
            put_write(pick_addr(), cmd_word(nfci_pkg::CMD_RESET));
         end
         14, 15, 16: put_write(pick_addr(), cmd_word(nfci_pkg::CMD_RESET));
         default: put_write(pick_addr(), 16'($urandom()));
      endcase
   endtask

   task automatic seq_erase();
      put_unlock();
      put_write(flash_cfg.unlock_first, cmd_word(nfci_pkg::CMD_ERASE));
      put_unlock();
      put_write(flash_cfg.unlock_first, cmd_word(nfci_pkg::CMD_CHIP_ERASE));
      put_read(pick_addr());
   endtask

   // follows the erase sequence part way, then breaks it
   task automatic seq_broken();
      logic [15:0] addrs [6];
      logic [7:0]  cmds [6];
      int unsigned stage;
      int unsigned k;
      logic [7:0]  b;
      addrs = '{flash_cfg.unlock_first, flash_cfg.unlock_second, flash_cfg.unlock_first,
                flash_cfg.unlock_first, flash_cfg.unlock_second, flash_cfg.unlock_first};
      cmds = '{nfci_pkg::CMD_UNLOCK_A, nfci_pkg::CMD_UNLOCK_B, nfci_pkg::CMD_ERASE,
               nfci_pkg::CMD_UNLOCK_A, nfci_pkg::CMD_UNLOCK_B, nfci_pkg::CMD_CHIP_ERASE};
      stage = $urandom_range(0, 5);
      for (k = 0; k < stage; k++) put_write(addrs[k], cmd_word(cmds[k]));
      b = 8'($urandom());
      if (b == cmds[stage]) b = ~b;
      case ($urandom_range(0, 3))
         0: put_write(addrs[stage] ^ 16'(1 << $urandom_range(0, 15)), cmd_word(cmds[stage]));
         1: put_write(addrs[stage], cmd_word(b));
         2: put_write(pick_addr(), cmd_word(nfci_pkg::CMD_RESET));
         default: put_write(16'($urandom()), {8'($urandom()), b});
      endcase
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned target;
      int unsigned r;
      target = words_queued + count;
      while (words_queued < target) begin
         r = $urandom_range(0, 99);
         if (r < 25) seq_program();
         else if (r < 37) seq_autoselect();
         else if (r < 55) seq_bypass();
         else if (r < 58) begin
            if (erase_left != 0) begin
               erase_left--;
               seq_erase();
            end else begin
               seq_broken();
            end
         end else if (r < 72) seq_broken();
         else if (r < 85) repeat ($urandom_range(1, 4)) put_read(pick_addr());
         else repeat ($urandom_range(1, 3))
            queue_word(bus_kind_type'($urandom_range(0, 1)), 16'($urandom()),
                       16'($urandom()));
      end
   endtask

   task automatic csr_write(input logic [nfci_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         nfci_pkg::CSR_UNLOCK_FIRST:  flash_cfg.unlock_first = val;
         nfci_pkg::CSR_UNLOCK_SECOND: flash_cfg.unlock_second = val;
         nfci_pkg::CSR_MAKER_CODE:    flash_cfg.maker_code = val;
         nfci_pkg::CSR_PART_CODE:     flash_cfg.part_code = val;
         nfci_pkg::CSR_PART_ADDR:     flash_cfg.part_addr = val;
         nfci_pkg::CSR_WIDE_BUS:      flash_cfg.wide_bus = val[0];
         default: ;
      endcase
   endtask

   task automatic set_cfg(input logic [15:0] first, input logic [15:0] second,
                          input logic [15:0] maker, input logic [15:0] part,
                          input logic [15:0] part_addr, input logic wide);
      csr_write(nfci_pkg::CSR_UNLOCK_FIRST, first);
      csr_write(nfci_pkg::CSR_UNLOCK_SECOND, second);
      csr_write(nfci_pkg::CSR_MAKER_CODE, maker);
      csr_write(nfci_pkg::CSR_PART_CODE, part);
      csr_write(nfci_pkg::CSR_PART_ADDR, part_addr);
      csr_write(nfci_pkg::CSR_WIDE_BUS, {15'd0, wide});
   endtask

   task automatic wait_idle();
      while (words_accepted != words_queued || rsp_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // request side
   always @(posedge clock) begin : req_accept
      flash_rsp_type e;
      if (!reset && req_valid && req_ready) begin
         flash_access(bus_kind_type'(req_kind), req_address, req_write_data, e);
         rsp_expected.push_back(e);
         words_accepted++;
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin : req_driver
      bus_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         req_taken = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bus_pending.size() != 0) begin
            w = bus_pending.pop_front();
            req_kind <= w.kind;
            req_address <= w.address;
            req_write_data <= w.write_data;
            req_valid <= 1'b1;
            gap_left = w.gap_after;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side
   always @(negedge clock) begin : rsp_stall
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 199) == 0) rsp_calm = !rsp_calm;
         rsp_hold = rsp_calm ? 0 : pick_gap();
      end
   end

   always @(posedge clock) begin : rsp_monitor
      flash_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expected.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected rsp word, expected none, actual %h %h %b", $time,
                     rsp_read_data, rsp_cmd_state, rsp_sequence_error);
         end else begin
            want = rsp_expected.pop_front();
            check_field("read_data", want.read_data, rsp_read_data);
            check_field("cmd_state", {12'd0, want.cmd_state}, {12'd0, rsp_cmd_state});
            check_field("sequence_error", {15'd0, want.seq_error}, {15'd0, rsp_sequence_error});
         end
      end
   end

   initial begin : main
      logic [15:0] a;
      flash_erase_all();
      flash_state = CS_ARRAY_READ;
      flash_cfg = '{nfci_pkg::RST_UNLOCK_FIRST, nfci_pkg::RST_UNLOCK_SECOND,
                    nfci_pkg::RST_MAKER_CODE, nfci_pkg::RST_PART_CODE,
                    nfci_pkg::RST_PART_ADDR, 1'b1};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults
      put_read(16'h0000);
      put_unlock();
      put_write(nfci_pkg::RST_UNLOCK_FIRST, {8'h00, nfci_pkg::CMD_PROGRAM});
      put_write(16'h0000, 16'h1234);
      put_read(16'h0000);
      put_unlock();
      put_write(nfci_pkg::RST_UNLOCK_FIRST, {8'h00, nfci_pkg::CMD_AUTOSELECT});
      put_read(16'h0000);
      put_read(nfci_pkg::RST_PART_ADDR);
      put_write(16'h0007, {8'h00, nfci_pkg::CMD_RESET});
      put_unlock();
      put_write(nfci_pkg::RST_UNLOCK_FIRST, {8'h00, nfci_pkg::CMD_BYPASS});
      put_write(16'hFFFF, {8'h00, nfci_pkg::CMD_PROGRAM});
      put_write(16'hFFFF, {8'h00, nfci_pkg::CMD_RESET});  // reset byte taken as program data
      put_read(16'hFFFF);
      put_write(16'h0003, {8'h00, nfci_pkg::CMD_AUTOSELECT});
      put_write(16'h1234, {8'h00, nfci_pkg::CMD_EXIT});
      put_write(nfci_pkg::RST_UNLOCK_FIRST + 16'd1, {8'h00, nfci_pkg::CMD_UNLOCK_A});
      put_unlock();
      put_write(nfci_pkg::RST_UNLOCK_SECOND, {8'h00, nfci_pkg::CMD_BYPASS});
      put_unlock();
      put_write(nfci_pkg::RST_UNLOCK_FIRST, {8'hFF, nfci_pkg::CMD_ERASE});
      put_unlock();
      put_write(nfci_pkg::RST_UNLOCK_FIRST, {8'h00, nfci_pkg::CMD_CHIP_ERASE});
      put_read(16'h0000);
      run_random(120);
      wait_idle();

      set_cfg(16'h0000, 16'hFFFF, 16'hFFFF, 16'h5AA5, 16'hFFFF, 1'b0);
      run_random(130);
      wait_idle();

      // device code address at zero: maker code wins
      set_cfg(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
      run_random(130);
      wait_idle();

      set_cfg(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      run_random(130);
      wait_idle();

      // both unlock cycles at one address
      a = 16'($urandom());
      set_cfg(a, a, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
      run_random(130);
      wait_idle();

      set_cfg(nfci_pkg::RST_UNLOCK_FIRST, nfci_pkg::RST_UNLOCK_SECOND,
              nfci_pkg::RST_MAKER_CODE, nfci_pkg::RST_PART_CODE,
              nfci_pkg::RST_PART_ADDR, 1'b1);
      run_random(130);
      wait_idle();
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
